@@ src/bsle_pkg.sv @@
// Shared types and constants for the bounded sequence list engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
package bsle_pkg;

	localparam int CAPACITY    = 32;
	localparam int MAX_RESULTS = 32;
	localparam int DATA_W      = 32;
	localparam int MODE_W      = 4;
	localparam int STATUS_W    = 2;
	localparam int OCC_W       = $clog2(CAPACITY + 1);
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	// Largest number of elements one readout can emit.
	localparam int CNT_LIMIT   = (MAX_RESULTS < CAPACITY) ? MAX_RESULTS : CAPACITY;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 4'd0,
		MODE_PUSH_BACK  = 4'd1,
		MODE_POP_FRONT  = 4'd2,
		MODE_POP_BACK   = 4'd3,
		MODE_DELETE     = 4'd4,
		MODE_FIRST_K    = 4'd5,
		MODE_LAST_K     = 4'd6,
		MODE_ALL        = 4'd7,
		MODE_CLEAR      = 4'd8
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_EMPTY   = 2'd2,
		STATUS_MISSING = 2'd3
	} status_t;

	// Operation classes handed from the front end to the back end.
	typedef enum logic [3:0] {
		OP_NOP        = 4'd0,
		OP_PUSH_FRONT = 4'd1,
		OP_PUSH_BACK  = 4'd2,
		OP_POP_FRONT  = 4'd3,
		OP_POP_BACK   = 4'd4,
		OP_DELETE     = 4'd5,
		OP_READ_FIRST = 4'd6,
		OP_READ_LAST  = 4'd7,
		OP_CLEAR      = 4'd8
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] value;
		logic [OCC_W-1:0]  k;     // readout length, already clamped to 0..CAPACITY
	} cmd_t;

endpackage

@@ src/bsle_in_if.sv @@
// Command channel of the bounded sequence list engine.
// Depends on bsle_pkg for the field widths.
interface bsle_in_if;
	logic                              valid;
	logic                              ready;
	logic [bsle_pkg::MODE_W-1:0]       mode;
	logic signed [bsle_pkg::DATA_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface

@@ src/bsle_out_if.sv @@
// Result channel of the bounded sequence list engine.
// Depends on bsle_pkg for the field widths.
interface bsle_out_if;
	logic                                valid;
	logic                                ready;
	logic                                has_element;
	logic signed [bsle_pkg::DATA_W-1:0]  element_value;
	logic                                is_final;
	logic [bsle_pkg::STATUS_W-1:0]       status;

	modport source (output valid, output has_element, output element_value,
		output is_final, output status, input ready);
	modport sink   (input valid, input has_element, input element_value,
		input is_final, input status, output ready);
endinterface

@@ src/bsle_front.sv @@
// Front end: accepts commands, decodes the mode and clamps the readout length.
// Depends on bsle_pkg and bsle_in_if.
module bsle_front (
	input  logic             clk,
	input  logic             arst_n,
	bsle_in_if.sink          cmd,
	output logic             dec_valid,
	input  logic             dec_ready,
	output bsle_pkg::cmd_t   dec_cmd
);

	logic           vld_s1;
	bsle_pkg::cmd_t cmd_s1;
	bsle_pkg::cmd_t decoded;
	logic           take;

	assign cmd.ready = !vld_s1 || dec_ready;
	assign take      = cmd.valid && cmd.ready;
	assign dec_valid = vld_s1;
	assign dec_cmd   = cmd_s1;

	always_comb begin
		decoded.value = cmd.value;
		// A length of zero or less reads nothing; anything above the capacity reads all.
		if (cmd.value[bsle_pkg::DATA_W-1] || cmd.value == '0) begin
			decoded.k = '0;
		end else if (cmd.value > $signed(32'(bsle_pkg::CAPACITY))) begin
			decoded.k = bsle_pkg::OCC_W'(bsle_pkg::CAPACITY);
		end else begin
			decoded.k = cmd.value[bsle_pkg::OCC_W-1:0];
		end
		unique case (bsle_pkg::mode_t'(cmd.mode))
			bsle_pkg::MODE_PUSH_FRONT: decoded.op = bsle_pkg::OP_PUSH_FRONT;
			bsle_pkg::MODE_PUSH_BACK:  decoded.op = bsle_pkg::OP_PUSH_BACK;
			bsle_pkg::MODE_POP_FRONT:  decoded.op = bsle_pkg::OP_POP_FRONT;
			bsle_pkg::MODE_POP_BACK:   decoded.op = bsle_pkg::OP_POP_BACK;
			bsle_pkg::MODE_DELETE:     decoded.op = bsle_pkg::OP_DELETE;
			bsle_pkg::MODE_FIRST_K:    decoded.op = bsle_pkg::OP_READ_FIRST;
			bsle_pkg::MODE_LAST_K:     decoded.op = bsle_pkg::OP_READ_LAST;
			bsle_pkg::MODE_ALL: begin
				decoded.op = bsle_pkg::OP_READ_FIRST;
				decoded.k  = bsle_pkg::OCC_W'(bsle_pkg::CAPACITY);
			end
			bsle_pkg::MODE_CLEAR:      decoded.op = bsle_pkg::OP_CLEAR;
			default:                   decoded.op = bsle_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= decoded;
		end
	end

endmodule

@@ src/bsle_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on bsle_pkg for the command type.
module bsle_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  bsle_pkg::cmd_t wr_cmd,
	output logic           rd_valid,
	input  logic           rd_ready,
	output bsle_pkg::cmd_t rd_cmd
);

	bsle_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_cmd   = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

@@ src/bsle_back.sv @@
// Back end: the cell chain, occupancy, readout sequencer and result register.
// Depends on bsle_pkg and bsle_out_if.
module bsle_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  bsle_pkg::cmd_t q_cmd,
	bsle_out_if.source     rsp
);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_READ = 2'b10
	} back_state_t;

	back_state_t                   state_q;
	logic [bsle_pkg::DATA_W-1:0]   cells_q [bsle_pkg::CAPACITY];
	logic [bsle_pkg::OCC_W-1:0]    occ_q;
	logic [bsle_pkg::IDX_W-1:0]    idx_q;
	logic [bsle_pkg::OCC_W-1:0]    rem_q;

	logic                          out_vld_q;
	logic                          out_has_q;
	logic [bsle_pkg::DATA_W-1:0]   out_val_q;
	logic                          out_fin_q;
	bsle_pkg::status_t             out_st_q;

	logic                          slot_free;
	logic                          take;
	logic                          is_full;
	logic                          is_empty;
	logic [bsle_pkg::CAPACITY-1:0] match;
	logic [bsle_pkg::CAPACITY-1:0] after_hit;
	logic                          found;
	logic                          is_read;
	logic [bsle_pkg::OCC_W-1:0]    n_sel;
	logic [bsle_pkg::OCC_W-1:0]    cnt;
	logic [bsle_pkg::OCC_W-1:0]    start;
	bsle_pkg::status_t             ack_st;

	assign slot_free = !out_vld_q || rsp.ready;
	assign q_ready   = (state_q == BK_IDLE) && slot_free;
	assign take      = q_valid && q_ready;
	assign is_full   = occ_q == bsle_pkg::OCC_W'(bsle_pkg::CAPACITY);
	assign is_empty  = occ_q == '0;

	// Each cell compares against the value on its own; after_hit marks the hit cell
	// and every cell behind it, which are the cells that close the gap.
	always_comb begin
		for (int i = 0; i < bsle_pkg::CAPACITY; i++) begin
			match[i] = (bsle_pkg::OCC_W'(i) < occ_q) && (cells_q[i] == q_cmd.value);
		end
		for (int i = 0; i < bsle_pkg::CAPACITY; i++) begin
			after_hit[i] = |(match << (bsle_pkg::CAPACITY - 1 - i));
		end
	end
	assign found = |match;

	assign is_read = (q_cmd.op == bsle_pkg::OP_READ_FIRST)
		|| (q_cmd.op == bsle_pkg::OP_READ_LAST);
	assign n_sel   = (q_cmd.k < occ_q) ? q_cmd.k : occ_q;
	assign cnt     = (n_sel > bsle_pkg::OCC_W'(bsle_pkg::CNT_LIMIT))
		? bsle_pkg::OCC_W'(bsle_pkg::CNT_LIMIT) : n_sel;
	assign start   = (q_cmd.op == bsle_pkg::OP_READ_LAST) ? occ_q - n_sel : '0;

	always_comb begin
		ack_st = bsle_pkg::STATUS_OK;
		unique case (q_cmd.op)
			bsle_pkg::OP_PUSH_FRONT,
			bsle_pkg::OP_PUSH_BACK: begin
				if (is_full) begin
					ack_st = bsle_pkg::STATUS_FULL;
				end
			end
			bsle_pkg::OP_POP_FRONT,
			bsle_pkg::OP_POP_BACK: begin
				if (is_empty) begin
					ack_st = bsle_pkg::STATUS_EMPTY;
				end
			end
			bsle_pkg::OP_DELETE: begin
				if (is_empty) begin
					ack_st = bsle_pkg::STATUS_EMPTY;
				end else if (!found) begin
					ack_st = bsle_pkg::STATUS_MISSING;
				end
			end
			bsle_pkg::OP_READ_FIRST,
			bsle_pkg::OP_READ_LAST: begin
				if (is_empty) begin
					ack_st = bsle_pkg::STATUS_EMPTY;
				end
			end
			default: ack_st = bsle_pkg::STATUS_OK;
		endcase
	end

	// Cell chain: each cell loads from its left neighbor, its right neighbor or the bus.
	for (genvar i = 0; i < bsle_pkg::CAPACITY; i++) begin : g_cell
		logic [bsle_pkg::DATA_W-1:0] left;
		logic [bsle_pkg::DATA_W-1:0] right;

		if (i == 0) begin : g_head
			assign left = q_cmd.value;
		end else begin : g_body
			assign left = cells_q[i-1];
		end
		if (i == bsle_pkg::CAPACITY - 1) begin : g_tail
			assign right = cells_q[i];
		end else begin : g_inner
			assign right = cells_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (take) begin
				unique case (q_cmd.op)
					bsle_pkg::OP_PUSH_FRONT: begin
						if (!is_full) begin
							cells_q[i] <= left;
						end
					end
					bsle_pkg::OP_PUSH_BACK: begin
						if (!is_full && occ_q == bsle_pkg::OCC_W'(i)) begin
							cells_q[i] <= q_cmd.value;
						end
					end
					bsle_pkg::OP_POP_FRONT: begin
						if (!is_empty) begin
							cells_q[i] <= right;
						end
					end
					bsle_pkg::OP_DELETE: begin
						if (after_hit[i]) begin
							cells_q[i] <= right;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			occ_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (take) begin
						if (is_read && cnt != '0) begin
							state_q <= BK_READ;
						end else begin
							out_vld_q <= 1'b1;
						end
						unique case (q_cmd.op)
							bsle_pkg::OP_PUSH_FRONT,
							bsle_pkg::OP_PUSH_BACK: begin
								if (!is_full) begin
									occ_q <= occ_q + 1'b1;
								end
							end
							bsle_pkg::OP_POP_FRONT,
							bsle_pkg::OP_POP_BACK: begin
								if (!is_empty) begin
									occ_q <= occ_q - 1'b1;
								end
							end
							bsle_pkg::OP_DELETE: begin
								if (found) begin
									occ_q <= occ_q - 1'b1;
								end
							end
							bsle_pkg::OP_CLEAR: occ_q <= '0;
							default: ;
						endcase
					end
				end
				BK_READ: begin
					if (slot_free) begin
						out_vld_q <= 1'b1;
						if (rem_q == bsle_pkg::OCC_W'(1)) begin
							state_q <= BK_IDLE;
						end
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q     <= start[bsle_pkg::IDX_W-1:0];
			rem_q     <= cnt;
			out_has_q <= 1'b0;
			out_val_q <= '0;
			out_fin_q <= 1'b1;
			out_st_q  <= ack_st;
		end else if (state_q == BK_READ && slot_free) begin
			idx_q     <= idx_q + 1'b1;
			rem_q     <= rem_q - 1'b1;
			out_has_q <= 1'b1;
			out_val_q <= cells_q[idx_q];
			out_fin_q <= rem_q == bsle_pkg::OCC_W'(1);
			out_st_q  <= bsle_pkg::STATUS_OK;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.has_element   = out_has_q;
	assign rsp.element_value = out_val_q;
	assign rsp.is_final      = out_fin_q;
	assign rsp.status        = out_st_q;

endmodule

@@ src/bounded_sequence_list_engine_core.sv @@
// Top level of the bounded sequence list engine: front end, command queue, back end.
// Depends on bsle_pkg, bsle_in_if, bsle_out_if, bsle_front, bsle_queue and bsle_back.

// The engine keeps an ordered list of up to 32 signed 32-bit values in a chain of
// cells, front at cell 0, and executes one command per transaction on the cmd
// channel. Push, pop, delete-by-value and clear are done by the whole cell chain at
// once (every cell compares or shifts in parallel) and return a single acknowledgement
// transaction with a status. A readout of n elements first sizes the range, then
// returns one element per cycle while rsp.ready takes them, from the cell chain's
// single read port, the last one flagged is_final; a readout that selects nothing
// returns one marker instead. So a stream of list updates sustains one command per
// cycle while rsp.ready takes each acknowledgement, and a readout holds the back end
// until its last element is sent. A command passes the decode register, then a
// two-entry queue, on its way to the back end, so the front end keeps taking
// commands while the back end streams a readout or waits on rsp.ready, until the
// queue fills. The back end holds while a result waits on rsp.ready, and it loads
// the next result in the same cycle that the previous one is taken.
// No clearing pass is needed after reset: only cells below the occupancy are read.
module bounded_sequence_list_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	bsle_in_if.sink    cmd,
	bsle_out_if.source rsp
);

	logic           dec_valid;
	logic           dec_ready;
	bsle_pkg::cmd_t dec_cmd;
	logic           q_valid;
	logic           q_ready;
	bsle_pkg::cmd_t q_cmd;

	// Decode the mode into an operation class and clamp the readout length.
	bsle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec_cmd   (dec_cmd)
	);

	// The queue decouples the two halves so either one can stall alone.
	bsle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (dec_valid),
		.wr_ready (dec_ready),
		.wr_cmd   (dec_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_cmd   (q_cmd)
	);

	// The back end owns all list state and drives the result channel.
	bsle_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cmd   (q_cmd),
		.rsp     (rsp)
	);

endmodule
